>>> design/bcml_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear color map lookup package
// Shared types and fixed constants of the color map recoloring block.
// ----------------------------------------------------------------------------
package bcml_pkg;

   // Request kinds.
   typedef enum logic {
      KIND_PIXEL = 1'b0,
      KIND_WRITE = 1'b1
   } kind_type;

   // One table entry or one RGB triple, red in element 0.
   typedef logic [2:0][15:0] color_type;

   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   // Luma weights in Q0.16; they sum to 65535.
   localparam logic [15:0] LUMA_WR = 16'd19589;
   localparam logic [15:0] LUMA_WG = 16'd38444;
   localparam logic [15:0] LUMA_WB = 16'd7502;

   localparam logic [16:0] ONE_Q16  = 17'd65536;
   localparam logic [16:0] HALF_Q16 = 17'd32768;

endpackage
`default_nettype wire

>>> design/bilinear_color_map_lookup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear color map lookup
// Recolors pixels through a bilinearly sampled MAP_SIZE x MAP_SIZE RGB table.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while req_stall is low, pixels
// and table writes mixed freely, and delivers one result per pixel; table
// writes give no result. The table lives in four single-read-port RAM
// banks split by the parity of row and column, so the four neighbors of a
// bilinear sample always fall into four different banks and are read in the
// same cycle. A table write is made from the stage 3 register and a pixel
// reads from the stage 4 register, so a pixel always sees every write that
// was accepted before it. The whole pipeline holds while a result waits in
// the output register and rsp_stall is high; req_stall then follows.
// No clearing pass is needed after reset: entries are undefined until written
// and must be written before any pixel samples them.
// ----------------------------------------------------------------------------
module bilinear_color_map_lookup #(
   parameter int MAP_SIZE        = 256,
   parameter int CHANNEL_BITS    = 16,
   parameter int COLOR_FRAC_BITS = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [16:0] req_depth,
   input  wire logic [15:0] req_red,
   input  wire logic [15:0] req_green,
   input  wire logic [15:0] req_blue,
   input  wire logic [15:0] req_alpha,
   input  wire logic [15:0] req_entry_index,
   input  wire logic [15:0] req_entry_red,
   input  wire logic [15:0] req_entry_green,
   input  wire logic [15:0] req_entry_blue,
   input  wire logic        req_frame_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_out_red,
   output logic [15:0]      rsp_out_green,
   output logic [15:0]      rsp_out_blue,
   output logic             rsp_out_last
);

   // Derived sizes.
   localparam int CW    = CHANNEL_BITS;
   localparam int FB    = COLOR_FRAC_BITS;
   localparam int CM    = (1 << CW) - 1;
   localparam int IW    = $clog2(MAP_SIZE);
   localparam int HALF  = (MAP_SIZE + 1) / 2;
   localparam int BDEP  = HALF * HALF;
   localparam int AW    = $clog2(BDEP);
   localparam int TABLE_N = MAP_SIZE * MAP_SIZE;
   localparam int XW    = CW + 17;
   localparam int PW    = CW + 34;
   localparam longint unsigned RECIP = 64'h1_0000_0000 / MAP_SIZE;

   typedef struct packed {
      logic [IW-1:0] lo;
      logic [IW-1:0] hi;
      logic [15:0]   frac;
   } axis_type;

   typedef struct packed {
      logic                vld;
      bcml_pkg::kind_type  kind;
      logic                pass;
      logic                last;
      bcml_pkg::color_type rgb;
      logic [16:0]         depth;
      logic [CW+15:0]      pr;
      logic [CW+15:0]      pg;
      logic [CW+15:0]      pb;
      logic [15:0]         idx;
      logic [15:0]         est;
      bcml_pkg::color_type entry;
   } s1_type;

   typedef struct packed {
      logic                pix;
      logic                wr;
      logic                pass;
      logic                last;
      bcml_pkg::color_type rgb;
      logic [16:0]         depth;
      logic [XW-1:0]       x;
      logic [IW-1:0]       row;
      logic [IW-1:0]       col;
      bcml_pkg::color_type entry;
   } s2_type;

   typedef struct packed {
      logic                pix;
      logic                wr;
      logic                pass;
      logic                last;
      bcml_pkg::color_type rgb;
      logic [16:0]         depth;
      logic [16:0]         luma;
      logic [1:0]          wbank;
      logic [AW-1:0]       waddr;
      bcml_pkg::color_type entry;
   } s3_type;

   typedef struct packed {
      logic                pix;
      logic                pass;
      logic                last;
      bcml_pkg::color_type rgb;
      axis_type            row;
      axis_type            col;
   } s4_type;

   typedef struct packed {
      logic                pix;
      logic                pass;
      logic                last;
      bcml_pkg::color_type rgb;
      logic                r0p;
      logic                r1p;
      logic                c0p;
      logic                c1p;
      logic [15:0]         fr;
      logic [15:0]         fc;
   } s5_type;

   typedef struct packed {
      logic                pix;
      logic                pass;
      logic                last;
      bcml_pkg::color_type rgb;
      logic [15:0]         fr;
      logic [2:0][32:0]    a0;
      logic [2:0][32:0]    a1;
   } s6_type;

   typedef struct packed {
      logic                pix;
      logic                pass;
      logic                last;
      bcml_pkg::color_type rgb;
      logic [2:0][49:0]    t;
   } s7_type;

   typedef struct packed {
      logic                pix;
      logic                pass;
      logic                last;
      bcml_pkg::color_type rgb;
      logic [2:0][PW-1:0]  m;
   } s8_type;

   // Texel-center sampling along one axis with clamped edges.
   function automatic axis_type axis_sample(input logic [16:0] v);
      logic [IW+17:0] pos;
      logic [IW+17:0] q;
      logic [IW+1:0]  l;
      logic [IW+1:0]  h;
      axis_type       a;
      pos = (IW+18)'(v) * (IW+18)'(MAP_SIZE);
      q   = pos - (IW+18)'(bcml_pkg::HALF_Q16);
      l   = q[IW+17:16];
      h   = l + (IW+2)'(1);
      if (l > (IW+2)'(MAP_SIZE - 1)) begin
         l = (IW+2)'(MAP_SIZE - 1);
      end
      if (h > (IW+2)'(MAP_SIZE - 1)) begin
         h = (IW+2)'(MAP_SIZE - 1);
      end
      a.lo   = l[IW-1:0];
      a.hi   = h[IW-1:0];
      a.frac = q[15:0];
      if (pos < (IW+18)'(bcml_pkg::HALF_Q16)) begin
         a = '0;
      end
      return a;
   endfunction

   function automatic logic [CW-1:0] sat_channel(input logic [15:0] v);
      logic [CW-1:0] s;
      s = (17'(v) > 17'(CM)) ? CW'(CM) : CW'(v);
      return s;
   endfunction

   logic   en;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   s6_type s6_ff, s6_in;
   s7_type s7_ff, s7_in;
   s8_type s8_ff, s8_in;

   logic                rsp_valid_ff, rsp_valid_in;
   bcml_pkg::color_type rsp_color_ff, rsp_color_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [3:0][AW-1:0]  rd_addr;
   bcml_pkg::color_type ram_q [4];

   // The pipeline moves as one; it holds only while a result waits.
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // Stage 1: register the request, form the luma products and start the
   // division of the write index by the map size through its reciprocal.
   always_comb begin
      logic [47:0] prod;
      s1_in       = '0;
      s1_in.vld   = req_valid;
      s1_in.kind  = bcml_pkg::kind_type'(req_kind);
      s1_in.pass  = (req_alpha == 16'd0);
      s1_in.last  = req_frame_last;
      s1_in.rgb[bcml_pkg::CH_RED]   = req_red;
      s1_in.rgb[bcml_pkg::CH_GREEN] = req_green;
      s1_in.rgb[bcml_pkg::CH_BLUE]  = req_blue;
      s1_in.depth = (req_depth > bcml_pkg::ONE_Q16) ? bcml_pkg::ONE_Q16 : req_depth;
      s1_in.pr = (CW+16)'(sat_channel(req_red))   * (CW+16)'(bcml_pkg::LUMA_WR);
      s1_in.pg = (CW+16)'(sat_channel(req_green)) * (CW+16)'(bcml_pkg::LUMA_WG);
      s1_in.pb = (CW+16)'(sat_channel(req_blue))  * (CW+16)'(bcml_pkg::LUMA_WB);
      s1_in.idx = req_entry_index;
      prod      = 48'(req_entry_index) * 48'(RECIP);
      s1_in.est = prod[47:32];
      s1_in.entry[bcml_pkg::CH_RED]   = req_entry_red;
      s1_in.entry[bcml_pkg::CH_GREEN] = req_entry_green;
      s1_in.entry[bcml_pkg::CH_BLUE]  = req_entry_blue;
   end

   // Stage 2: luma sum with rounding; the quotient estimate is short by at
   // most one, so a single compare fixes row and column.
   always_comb begin
      logic [16:0] rem;
      logic [15:0] row;
      s2_in       = '0;
      s2_in.pix   = s1_ff.vld && (s1_ff.kind == bcml_pkg::KIND_PIXEL);
      s2_in.wr    = s1_ff.vld && (s1_ff.kind == bcml_pkg::KIND_WRITE) &&
                    (21'(s1_ff.idx) < 21'(TABLE_N));
      s2_in.pass  = s1_ff.pass;
      s2_in.last  = s1_ff.last;
      s2_in.rgb   = s1_ff.rgb;
      s2_in.depth = s1_ff.depth;
      s2_in.x     = XW'(s1_ff.pr) + XW'(s1_ff.pg) + XW'(s1_ff.pb) + XW'(CM / 2);
      rem = 17'(s1_ff.idx) - 17'(27'(s1_ff.est) * 27'(MAP_SIZE));
      row = s1_ff.est;
      if (rem >= 17'(MAP_SIZE)) begin
         rem = rem - 17'(MAP_SIZE);
         row = row + 16'd1;
      end
      s2_in.row   = row[IW-1:0];
      s2_in.col   = rem[IW-1:0];
      s2_in.entry = s1_ff.entry;
   end

   // Stage 3: luma divided by the channel maximum 2^CW - 1. Each fold keeps
   // x = q*M + rest exact while shrinking the rest; two compares finish it.
   always_comb begin
      logic [XW-1:0] x;
      logic [XW-1:0] q;
      s3_in       = '0;
      s3_in.pix   = s2_ff.pix;
      s3_in.wr    = s2_ff.wr;
      s3_in.pass  = s2_ff.pass;
      s3_in.last  = s2_ff.last;
      s3_in.rgb   = s2_ff.rgb;
      s3_in.depth = s2_ff.depth;
      x = s2_ff.x;
      q = '0;
      for (int i = 0; i < 3; i++) begin
         q = q + (x >> CW);
         x = (x >> CW) + (x & XW'(CM));
      end
      if (x >= XW'(2 * CM)) begin
         q = q + XW'(2);
      end else if (x >= XW'(CM)) begin
         q = q + XW'(1);
      end
      s3_in.luma  = q[16:0];
      s3_in.wbank = {s2_ff.row[0], s2_ff.col[0]};
      s3_in.waddr = AW'(s2_ff.row[IW-1:1]) * AW'(HALF) + AW'(s2_ff.col[IW-1:1]);
      s3_in.entry = s2_ff.entry;
   end

   // Stage 4: sample positions along both axes.
   always_comb begin
      s4_in      = '0;
      s4_in.pix  = s3_ff.pix;
      s4_in.pass = s3_ff.pass;
      s4_in.last = s3_ff.last;
      s4_in.rgb  = s3_ff.rgb;
      s4_in.row  = axis_sample(s3_ff.depth);
      s4_in.col  = axis_sample(s3_ff.luma);
   end

   // Bank addresses: each bank serves the neighbor row and column of its own
   // parity. Where low and high coincide the other bank's word goes unused.
   always_comb begin
      logic [IW-1:0] r;
      logic [IW-1:0] c;
      for (int b = 0; b < 4; b++) begin
         r = (s4_ff.row.lo[0] == b[1]) ? s4_ff.row.lo : s4_ff.row.hi;
         c = (s4_ff.col.lo[0] == b[0]) ? s4_ff.col.lo : s4_ff.col.hi;
         rd_addr[b] = AW'(r[IW-1:1]) * AW'(HALF) + AW'(c[IW-1:1]);
      end
   end

   for (genvar gb = 0; gb < 4; gb++) begin : g_bank
      bcml_ram #(
         .WIDTH (48),
         .DEPTH (BDEP)
      ) u_ram (
         .clock   (clock),
         .wr_en   (en && s3_ff.wr && (s3_ff.wbank == 2'(gb))),
         .wr_addr (s3_ff.waddr),
         .wr_data (s3_ff.entry),
         .rd_en   (en),
         .rd_addr (rd_addr[gb]),
         .rd_data (ram_q[gb])
      );
   end

   // Stage 5: keep the parities that pick each neighbor out of the banks, and the fractions.
   always_comb begin
      s5_in      = '0;
      s5_in.pix  = s4_ff.pix;
      s5_in.pass = s4_ff.pass;
      s5_in.last = s4_ff.last;
      s5_in.rgb  = s4_ff.rgb;
      s5_in.r0p  = s4_ff.row.lo[0];
      s5_in.r1p  = s4_ff.row.hi[0];
      s5_in.c0p  = s4_ff.col.lo[0];
      s5_in.c1p  = s4_ff.col.hi[0];
      s5_in.fr   = s4_ff.row.frac;
      s5_in.fc   = s4_ff.col.frac;
   end

   // Stage 6: horizontal blend along the luma axis, both rows.
   always_comb begin
      bcml_pkg::color_type e00, e01, e10, e11;
      logic [16:0] wc0;
      e00 = ram_q[{s5_ff.r0p, s5_ff.c0p}];
      e01 = ram_q[{s5_ff.r0p, s5_ff.c1p}];
      e10 = ram_q[{s5_ff.r1p, s5_ff.c0p}];
      e11 = ram_q[{s5_ff.r1p, s5_ff.c1p}];
      wc0 = bcml_pkg::ONE_Q16 - 17'(s5_ff.fc);
      s6_in      = '0;
      s6_in.pix  = s5_ff.pix;
      s6_in.pass = s5_ff.pass;
      s6_in.last = s5_ff.last;
      s6_in.rgb  = s5_ff.rgb;
      s6_in.fr   = s5_ff.fr;
      for (int ch = 0; ch < 3; ch++) begin
         s6_in.a0[ch] = 33'(e00[ch]) * 33'(wc0) + 33'(e01[ch]) * 33'(s5_ff.fc);
         s6_in.a1[ch] = 33'(e10[ch]) * 33'(wc0) + 33'(e11[ch]) * 33'(s5_ff.fc);
      end
   end

   // Stage 7: vertical blend along the depth axis.
   always_comb begin
      logic [16:0] wr0;
      wr0 = bcml_pkg::ONE_Q16 - 17'(s6_ff.fr);
      s7_in      = '0;
      s7_in.pix  = s6_ff.pix;
      s7_in.pass = s6_ff.pass;
      s7_in.last = s6_ff.last;
      s7_in.rgb  = s6_ff.rgb;
      for (int ch = 0; ch < 3; ch++) begin
         s7_in.t[ch] = 50'(s6_ff.a0[ch]) * 50'(wr0) + 50'(s6_ff.a1[ch]) * 50'(s6_ff.fr);
      end
   end

   // Stage 8: round to Q.16 and scale from table units to channel units.
   always_comb begin
      logic [49:0] tr;
      s8_in      = '0;
      s8_in.pix  = s7_ff.pix;
      s8_in.pass = s7_ff.pass;
      s8_in.last = s7_ff.last;
      s8_in.rgb  = s7_ff.rgb;
      for (int ch = 0; ch < 3; ch++) begin
         tr = s7_ff.t[ch] + 50'(bcml_pkg::HALF_Q16);
         s8_in.m[ch] = PW'(tr[49:16]) * PW'(CM) + (PW'(1) << (FB + 15));
      end
   end

   // Output register: final shift and clamp, or the untouched transparent
   // pixel.
   always_comb begin
      logic [PW-1:0] v;
      rsp_valid_in = s8_ff.pix;
      rsp_last_in  = s8_ff.last;
      for (int ch = 0; ch < 3; ch++) begin
         v = s8_ff.m[ch] >> (FB + 16);
         if (v > PW'(CM)) begin
            v = PW'(CM);
         end
         rsp_color_in[ch] = s8_ff.pass ? s8_ff.rgb[ch] : v[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '0;
         s2_ff        <= '0;
         s3_ff        <= '0;
         s4_ff        <= '0;
         s5_ff        <= '0;
         s6_ff        <= '0;
         s7_ff        <= '0;
         s8_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         s3_ff        <= s3_in;
         s4_ff        <= s4_in;
         s5_ff        <= s5_in;
         s6_ff        <= s6_in;
         s7_ff        <= s7_in;
         s8_ff        <= s8_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_color_ff <= rsp_color_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_color_ff[bcml_pkg::CH_RED];
   assign rsp_out_green = rsp_color_ff[bcml_pkg::CH_GREEN];
   assign rsp_out_blue  = rsp_color_ff[bcml_pkg::CH_BLUE];
   assign rsp_out_last  = rsp_last_ff;

endmodule
`default_nettype wire

>>> design/bcml_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bcml_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> tb/bcml_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bilinear color map lookup checker
// Watches both channels, keeps a shadow color table, predicts each recolored
// pixel and compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
module bcml_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic        req_kind,
   input  wire logic [16:0] req_depth,
   input  wire logic [15:0] req_red,
   input  wire logic [15:0] req_green,
   input  wire logic [15:0] req_blue,
   input  wire logic [15:0] req_alpha,
   input  wire logic [15:0] req_entry_index,
   input  wire logic [15:0] req_entry_red,
   input  wire logic [15:0] req_entry_green,
   input  wire logic [15:0] req_entry_blue,
   input  wire logic        req_frame_last,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [15:0] rsp_out_red,
   input  wire logic [15:0] rsp_out_green,
   input  wire logic [15:0] rsp_out_blue,
   input  wire logic        rsp_out_last,
   output int               errors,
   output int               pending
);

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic        last;
   } pixel_type;

   localparam longint unsigned CH_MAX = 65535;

   bcml_pkg::color_type shadow_table [65536];
   pixel_type           expected_pixels [$];

   // Texel-center sampling along one axis, clamped at both edges.
   function automatic void axis_sample(input longint unsigned v, output int lo,
                                       output int hi, output longint unsigned frac);
      longint unsigned pos;
      longint unsigned q;
      pos = 256 * v;
      if (pos < 32768) begin
         lo = 0; hi = 0; frac = 0;
      end else begin
         q = pos - 32768;
         lo = int'(q >> 16);
         hi = lo + 1;
         if (lo > 255) lo = 255;
         if (hi > 255) hi = 255;
         frac = q & 16'hFFFF;
      end
   endfunction

   function automatic pixel_type recolor(input logic [16:0] depth, input logic [15:0] r,
                                         input logic [15:0] g, input logic [15:0] b,
                                         input logic [15:0] alpha, input logic last);
      pixel_type res;
      longint unsigned d, luma, fr, fc, a0, a1, t, t16, v;
      int r0, r1, c0, c1;
      logic [15:0] chan [3];
      if (alpha == 0) begin
         res = '{red: r, green: g, blue: b, last: last};
         return res;
      end
      d = (depth > bcml_pkg::ONE_Q16) ? bcml_pkg::ONE_Q16 : depth;
      luma = (bcml_pkg::LUMA_WR * longint'(r) + bcml_pkg::LUMA_WG * longint'(g)
              + bcml_pkg::LUMA_WB * longint'(b) + CH_MAX / 2) / CH_MAX;
      axis_sample(d, r0, r1, fr);
      axis_sample(luma, c0, c1, fc);
      for (int ch = 0; ch < 3; ch++) begin
         a0 = shadow_table[r0*256+c0][ch] * (65536 - fc) + shadow_table[r0*256+c1][ch] * fc;
         a1 = shadow_table[r1*256+c0][ch] * (65536 - fc) + shadow_table[r1*256+c1][ch] * fc;
         t = a0 * (65536 - fr) + a1 * fr;
         t16 = (t + 32768) >> 16;
         v = (t16 * CH_MAX + (64'd1 << 27)) >> 28;
         chan[ch] = (v > CH_MAX) ? 16'hFFFF : v[15:0];
      end
      res = '{red: chan[bcml_pkg::CH_RED], green: chan[bcml_pkg::CH_GREEN],
              blue: chan[bcml_pkg::CH_BLUE], last: last};
      return res;
   endfunction

   // Sampling at the falling edge: a request seen valid and unstalled here is
   // accepted at the next rising edge, since the testbench drives only there.
   always @(negedge clock) begin
      pixel_type want;
      pixel_type got;
      if (reset) begin
         errors = 0;
         expected_pixels.delete();
      end else begin
         if (req_valid && !req_stall) begin
            if (req_kind == bcml_pkg::KIND_WRITE)
               shadow_table[req_entry_index] = {req_entry_blue, req_entry_green, req_entry_red};
            else
               expected_pixels.push_back(recolor(req_depth, req_red, req_green, req_blue,
                                                 req_alpha, req_frame_last));
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{red: rsp_out_red, green: rsp_out_green, blue: rsp_out_blue,
                    last: rsp_out_last};
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected result %h", $time, got);
               errors++;
            end else begin
               want = expected_pixels.pop_front();
               if (got !== want) begin
                  $display({"%0t: mismatch expected r=%h g=%h b=%h last=%b",
                            " got r=%h g=%h b=%h last=%b"},
                           $time, want.red, want.green, want.blue, want.last,
                           got.red, got.green, got.blue, got.last);
                  errors++;
               end
            end
         end
      end
      pending = expected_pixels.size();
   end

endmodule

>>> tb/tb_bilinear_color_map_lookup.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bilinear color map lookup testbench
// Streams table writes and pixels into the block under random idling on both
// channels; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_bilinear_color_map_lookup;

   localparam int REQUEST_TARGET = 1150;
   localparam int CYCLE_LIMIT    = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = bcml_pkg::KIND_PIXEL;
   logic [16:0] req_depth = '0;
   logic [15:0] req_red = '0, req_green = '0, req_blue = '0, req_alpha = '0;
   logic [15:0] req_entry_index = '0;
   logic [15:0] req_entry_red = '0, req_entry_green = '0, req_entry_blue = '0;
   logic        req_frame_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_out_red, rsp_out_green, rsp_out_blue;
   logic        rsp_out_last;
   int          errors;
   int          pending;

   // Idle percentages of the sender and the receiver for the current phase.
   int          send_idle_pct = 7;
   int          recv_stall_pct = 80;
   int          request_count = 0;
   int          cycle_count = 0;

   // Entries written since reset; a pixel may only sample written entries.
   bit          entry_written [65536];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bilinear_color_map_lookup i_dut (.*);

   bcml_checker i_checker (.*);

   // The receiver stalls at random with the percentage of the current phase.
   always @(posedge clock)
      rsp_stall <= !reset && ($urandom_range(99) < recv_stall_pct);

   // A watchdog so that a hung block still produces a verdict.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Drives one request, with optional idle cycles first, and returns at the
   // rising edge where it is accepted. Stall is read at the falling edge, when
   // nothing on the channel can change before the next rising edge.
   task automatic send_request(input logic kind, input logic [16:0] depth,
                               input logic [15:0] r, input logic [15:0] g,
                               input logic [15:0] b, input logic [15:0] alpha,
                               input logic [15:0] index, input logic [15:0] er,
                               input logic [15:0] eg, input logic [15:0] eb,
                               input logic last);
      bit stalled;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_depth <= depth;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      req_alpha <= alpha;
      req_entry_index <= index;
      req_entry_red <= er;
      req_entry_green <= eg;
      req_entry_blue <= eb;
      req_frame_last <= last;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      request_count++;
   endtask

   // Table write with random pixel fields, which the block must ignore.
   task automatic write_entry(input logic [15:0] index, input logic [15:0] er,
                              input logic [15:0] eg, input logic [15:0] eb);
      send_request(bcml_pkg::KIND_WRITE, 17'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), index, er, eg, eb, 1'($urandom));
      entry_written[index] = 1'b1;
   endtask

   // Row or column pair touched by a sample at v (Q0.16), edges clamped.
   function automatic void texel_pair(input longint unsigned v, output int lo, output int hi);
      longint unsigned q;
      if (256 * v < 32768) begin
         lo = 0; hi = 0;
      end else begin
         q = 256 * v - 32768;
         lo = (q >> 16) > 255 ? 255 : int'(q >> 16);
         hi = lo + 1 > 255 ? 255 : lo + 1;
      end
   endfunction

   // Sends a pixel, first writing any of its four neighbor entries that has
   // never been written, so that no undefined entry is ever sampled.
   task automatic recolor_pixel(input logic [16:0] depth, input logic [15:0] r,
                                input logic [15:0] g, input logic [15:0] b,
                                input logic [15:0] alpha, input logic last);
      int r0, r1, c0, c1;
      int idx [4];
      longint unsigned luma;
      if (alpha != 0) begin
         luma = (19589 * longint'(r) + 38444 * longint'(g) + 7502 * longint'(b) + 32767)
                / 65535;
         texel_pair(depth > 65536 ? 65536 : depth, r0, r1);
         texel_pair(luma, c0, c1);
         idx = '{r0*256+c0, r0*256+c1, r1*256+c0, r1*256+c1};
         foreach (idx[k])
            if (!entry_written[idx[k]])
               write_entry(16'(idx[k]), 16'($urandom), 16'($urandom), 16'($urandom));
      end
      send_request(bcml_pkg::KIND_PIXEL, depth, r, g, b, alpha, 16'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom), last);
   endtask

   task automatic random_traffic(input int stop_count);
      logic [16:0] depth;
      logic [15:0] r, g, b;
      int pick;
      while (request_count < stop_count) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            // Stray writes anywhere in the table, sometimes with extreme colors.
            if ($urandom_range(3) == 0)
               write_entry(16'($urandom), 16'hFFFF, 16'h0000, 16'hFFFF);
            else
               write_entry(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
         end else begin
            depth = ($urandom_range(9) == 0) ? 17'($urandom_range(65536, 131071))
                                              : 17'($urandom_range(0, 65536));
            r = 16'($urandom);
            g = 16'($urandom);
            b = 16'($urandom);
            if (pick < 25)
               recolor_pixel(depth, r, g, b, 16'h0000, 1'($urandom));
            else
               recolor_pixel(depth, r, g, b, 16'($urandom_range(1, 65535)), 1'($urandom));
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Corners of the table with full-scale and zero colors, so the output
      // clamp and the edge clamping along both axes are exercised.
      write_entry(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      write_entry(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
      write_entry(16'hFF00, 16'h1000, 16'h0800, 16'h0001);
      write_entry(16'h00FF, 16'h1000, 16'hFFFF, 16'h0000);
      recolor_pixel(17'd0, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b0);
      recolor_pixel(17'd65536, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 1'b1);
      recolor_pixel(17'h1FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      recolor_pixel(17'h1FFFF, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 1'b1);
      recolor_pixel(17'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 1'b0);
      recolor_pixel(17'd127, 16'h0000, 16'h0000, 16'h00FF, 16'hFFFF, 1'b0);
      recolor_pixel(17'd128, 16'h0080, 16'h0000, 16'h0000, 16'hFFFF, 1'b1);
      recolor_pixel(17'd32768, 16'h8000, 16'h8000, 16'h8000, 16'h1234, 1'b0);
      // Transparent pixels pass their channels through untouched.
      recolor_pixel(17'h1FFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b1);
      recolor_pixel(17'd0, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);

      random_traffic(REQUEST_TARGET / 3);
      send_idle_pct = 80;
      recv_stall_pct = 7;
      random_traffic(2 * REQUEST_TARGET / 3);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      random_traffic(REQUEST_TARGET);
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
